/* rtl/swet_pkg.sv */
// Shared constants and field widths for the sliding-window elapsed-time meter.
package swet_pkg;

  localparam int MaxSlices = 32;

  localparam int SecW      = 32;
  localparam int MsW       = 10;
  localparam int WinW      = 5;
  localparam int SpanW     = 32;
  localparam int IntervalW = 5;
  localparam int StampW    = SecW + MsW;

  localparam logic [MsW-1:0]  MsPerSec  = 10'd1000;
  localparam logic [WinW-1:0] WinReset  = 5'd1;

  localparam logic ActStart  = 1'b0;
  localparam logic ActSample = 1'b1;

endpackage

/* rtl/sliding_window_elapsed_time.sv */
// Sliding-window elapsed-time meter: a request is taken every cycle while in_stall_o is low;
// its result, if any, passes through the input register, ring update and read of the oldest
// stamp, and subtract and saturate into the output register; downstream stall holds the
// pipeline and stalls upstream only when every stage is full. Start requests record a stamp
// and give no result. The stamp ring is a RAM of MaxSlices entries holding
// seconds*1000+millis; its one registered read of the oldest stamp per cycle sets the
// one-request-per-cycle rate. The window length register takes effect at the next start.
module sliding_window_elapsed_time #(
  parameter int MaxSlices = swet_pkg::MaxSlices
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [swet_pkg::WinW-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [swet_pkg::SecW-1:0]      stamp_seconds_i,
  input  logic [swet_pkg::MsW-1:0]       stamp_millis_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [swet_pkg::SpanW-1:0]     span_ms_o,
  output logic [swet_pkg::IntervalW-1:0] intervals_in_window_o
);

  localparam int AW   = $clog2(MaxSlices);
  localparam int LenW = AW + 1;

  // window register
  logic [swet_pkg::WinW-1:0] win_q;
  logic [swet_pkg::WinW-1:0] win_d;

  always_comb begin
    priority if (32'(cfg_wdata_i) >= 32'(MaxSlices)) begin
      win_d = swet_pkg::WinW'(MaxSlices - 1);
    end else if (cfg_wdata_i == '0) begin
      win_d = swet_pkg::WinW'(1);
    end else begin
      win_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= swet_pkg::WinReset;
    end else if (cfg_we_i) begin
      win_q <= win_d;
    end
  end

  // handshake chain
  logic v1_q, v2_q, ov_q;
  logic ready_out, ready2, ready1, adv1, in_acc;

  assign ready_out  = !ov_q || !out_stall_i;
  assign ready2     = !v2_q || ready_out;
  assign adv1       = v1_q && ready2;
  assign ready1     = !v1_q || ready2;
  assign in_acc     = in_valid_i && ready1;
  assign in_stall_o = !ready1;

  // input register
  logic                      act1_q;
  logic [swet_pkg::SecW-1:0] sec1_q;
  logic [swet_pkg::MsW-1:0]  ms1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ready1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act1_q <= action_i;
      sec1_q <= stamp_seconds_i;
      ms1_q  <= stamp_millis_i;
    end
  end

  // ring state update
  logic [AW-1:0]   head_q, head_d;
  logic [LenW-1:0] fill_q, fill_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] head_inc, back, head_ext;
  logic [AW-1:0]   oldest;
  logic [swet_pkg::StampW-1:0] now1;
  logic            is_sample;

  assign is_sample = (act1_q == swet_pkg::ActSample);
  assign now1 = swet_pkg::StampW'(sec1_q) * swet_pkg::StampW'(swet_pkg::MsPerSec)
              + swet_pkg::StampW'(ms1_q);

  always_comb begin
    head_inc = LenW'(head_q) + LenW'(1);
    head_d   = head_q;
    fill_d   = fill_q;
    len_d    = len_q;
    if (is_sample) begin
      head_d = (head_inc >= len_q) ? '0 : AW'(head_inc);
      fill_d = (fill_q < len_q) ? fill_q + LenW'(1) : fill_q;
    end else begin
      head_d = '0;
      fill_d = LenW'(1);
      len_d  = LenW'(win_q) + LenW'(1);
    end
    back     = fill_d - LenW'(1);
    head_ext = LenW'(head_d);
    // oldest slot, wrapped within the current ring length
    if (head_ext >= back) begin
      oldest = AW'(head_ext - back);
    end else begin
      oldest = AW'(head_ext + len_q - back);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      len_q  <= LenW'(swet_pkg::WinReset) + LenW'(1);
    end else if (adv1) begin
      head_q <= head_d;
      fill_q <= fill_d;
      len_q  <= len_d;
    end
  end

  logic [swet_pkg::StampW-1:0] rdata;

  swet_ram #(
    .Width (swet_pkg::StampW),
    .Depth (MaxSlices)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (adv1),
    .waddr_i (head_d),
    .wdata_i (now1),
    .re_i    (adv1 && is_sample),
    .raddr_i (oldest),
    .rdata_o (rdata)
  );

  // second stage: stamp pair and interval count
  logic [swet_pkg::StampW-1:0]    now2_q;
  logic [swet_pkg::IntervalW-1:0] back2_q;
  logic                           zero2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ready2) begin
      v2_q <= adv1 && is_sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && is_sample) begin
      now2_q  <= now1;
      back2_q <= swet_pkg::IntervalW'(back);
      zero2_q <= (back == '0);
    end
  end

  // subtract and saturate
  logic [swet_pkg::StampW-1:0] diff;
  logic [swet_pkg::SpanW-1:0]  span_d;

  assign diff = now2_q - rdata;

  always_comb begin
    // single-stamp window reads its own slot, so the span is forced to zero
    priority if (zero2_q || now2_q < rdata) begin
      span_d = '0;
    end else if (diff[swet_pkg::StampW-1:swet_pkg::SpanW] != '0) begin
      span_d = '1;
    end else begin
      span_d = diff[swet_pkg::SpanW-1:0];
    end
  end

  logic [swet_pkg::SpanW-1:0]     span_q;
  logic [swet_pkg::IntervalW-1:0] intv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ready_out) begin
      ov_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_out && v2_q) begin
      span_q <= span_d;
      intv_q <= back2_q;
    end
  end

  assign out_valid_o           = ov_q;
  assign span_ms_o             = span_q;
  assign intervals_in_window_o = intv_q;

endmodule

/* rtl/swet_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module swet_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/swet_checker.sv */
// Port-level checker for the elapsed-time meter, bound to the top level.
module swet_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [swet_pkg::WinW-1:0]      cfg_wdata_i,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           action_i,
  input logic [swet_pkg::SecW-1:0]      stamp_seconds_i,
  input logic [swet_pkg::MsW-1:0]       stamp_millis_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [swet_pkg::SpanW-1:0]     span_ms_o,
  input logic [swet_pkg::IntervalW-1:0] intervals_in_window_o
);

  // interval count of the last delivered result
  logic [swet_pkg::IntervalW:0] last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      last_q <= {1'b0, intervals_in_window_o};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(span_ms_o) && $stable(intervals_in_window_o))
    else $error("stalled result changed");

  a_zero_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && intervals_in_window_o == '0 |-> span_ms_o == '0)
    else $error("nonzero span with no intervals");

  a_interval_growth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, intervals_in_window_o} <= last_q + 1'b1)
    else $error("interval count grew by more than one");

endmodule

bind sliding_window_elapsed_time swet_checker u_swet_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .cfg_we_i              (cfg_we_i),
  .cfg_wdata_i           (cfg_wdata_i),
  .in_valid_i            (in_valid_i),
  .in_stall_o            (in_stall_o),
  .action_i              (action_i),
  .stamp_seconds_i       (stamp_seconds_i),
  .stamp_millis_i        (stamp_millis_i),
  .out_valid_o           (out_valid_o),
  .out_stall_i           (out_stall_i),
  .span_ms_o             (span_ms_o),
  .intervals_in_window_o (intervals_in_window_o)
);
